@@ rtl/dra_pkg.sv @@
`default_nettype none

package dra_pkg;

    localparam int ENTRIES    = 16;
    localparam int PAGE_SHIFT = 12;

    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 44;
    localparam int SIZE_W   = 42;
    localparam int FLAGS_W  = 8;
    localparam int BASE_W   = 32;
    localparam int PAGES_W  = 30;
    localparam int PROT_W   = 16;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;
    localparam int CFG_W    = 30;
    localparam int CFG_IDX_W = 2;

    // Widths wide enough to compare a stored page value, shifted back to bytes, with a request.
    localparam int CMP_A_W = (BASE_W + PAGE_SHIFT > ADDR_W) ? BASE_W + PAGE_SHIFT : ADDR_W;
    localparam int CMP_S_W = (PAGES_W + PAGE_SHIFT > SIZE_W) ? PAGES_W + PAGE_SHIFT : SIZE_W;

    localparam int IN_W  = MODE_W + ADDR_W + SIZE_W;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = 1 + STATUS_W + INDEX_W;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_RELEASE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_SIZE_ALIGN = 3'd2,
        ST_ADDR_ALIGN = 3'd3,
        ST_TOO_LARGE  = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLAGS_ALLOW    = 2'd0,
        CFG_SIZE_MAX_PAGES = 2'd1,
        CFG_PROTECTED_MASK = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_WAIT = 2'd2
    } state_t;

    // Request as broadcast to every cell during a scan.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ADDR_W-1:0]  address;
        logic [SIZE_W-1:0]  size_bytes;
        logic [BASE_W-1:0]  base_page;
        logic [PAGES_W-1:0] size_pages;
        status_t            add_status;
    } req_t;

    // What a cell reports when the scan token stops at it.
    typedef struct packed {
        logic               hit;
        status_t            status;
        logic [INDEX_W-1:0] index;
    } cell_res_t;

endpackage

`default_nettype wire

@@ rtl/dra_cell.sv @@
`default_nettype none

module dra_cell import dra_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               tok_in,
    input  wire req_t               req,
    input  wire logic [FLAGS_W-1:0] grant_flags,
    input  wire logic               prot,
    input  wire logic [INDEX_W-1:0] idx,
    output logic                    tok_out,
    output cell_res_t               res
);

    logic               tok_reg;
    logic [FLAGS_W-1:0] flags_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [PAGES_W-1:0] size_reg;

    logic free;
    logic active;
    logic base_match;
    logic size_match;
    logic wr_add;
    logic clr;

    assign free       = !prot && (flags_reg == '0);
    assign active     = !prot && (flags_reg != '0);
    assign base_match = ((CMP_A_W'(base_reg) << PAGE_SHIFT) == CMP_A_W'(req.address));
    assign size_match = ((CMP_S_W'(size_reg) << PAGE_SHIFT) == CMP_S_W'(req.size_bytes));

    always_comb
    begin
        res.hit    = 1'b0;
        res.status = ST_OK;
        res.index  = '0;
        wr_add     = 1'b0;
        clr        = 1'b0;
        if (tok_reg)
        begin
            case (mode_t'(req.mode))
                MODE_ADD:
                begin
                    // The first free entry settles an add, whether the checks pass or not.
                    if (free)
                    begin
                        res.hit    = 1'b1;
                        res.status = req.add_status;
                        if (req.add_status == ST_OK)
                        begin
                            wr_add    = 1'b1;
                            res.index = idx;
                        end
                    end
                end
                MODE_REMOVE:
                begin
                    if (active && base_match && size_match)
                    begin
                        res.hit   = 1'b1;
                        res.index = idx;
                        clr       = 1'b1;
                    end
                end
                MODE_RELEASE:
                begin
                    clr = !prot;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign tok_out = tok_reg && !res.hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 1'b0;
            flags_reg <= '0;
            base_reg  <= '0;
            size_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (wr_add)
            begin
                flags_reg <= grant_flags;
                base_reg  <= req.base_page;
                size_reg  <= req.size_pages;
            end
            else if (clr)
            begin
                flags_reg <= '0;
                base_reg  <= '0;
                size_reg  <= '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/dma_region_allowlist_table_top.sv @@
`default_nettype none

// DMA region allow-list table. Each input word is one command (add, remove or release)
// and produces exactly one result word. The table lives in a row of ENTRIES cells, one
// entry per cell, and a scan token moves from one cell to the next each cycle; a command
// ends at the first cell that settles it or at the end of the row. The result word is
// registered when the scan ends, settled in entry 0 at the earliest or at the last entry
// at the latest, and the input opens again once the scan ends, so a command that walks
// the whole row keeps the input closed for the whole scan.
// A finished result waits in the output register, or in one holding register behind it
// when the output is still occupied; in that case the input stays closed until the
// output word is taken. Configuration writes take effect on the next cycle and must only
// be issued while no command is in flight.

module dma_region_allowlist_table_top import dra_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_TW-1:0]     s_tdata,   // mode[1:0], address[45:2], size_bytes[87:46]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_TW-1:0]         m_tdata    // ok[0], status[3:1], entry_index[7:4]
);

    logic [FLAGS_W-1:0] grant_flags_reg;
    logic [PAGES_W-1:0] size_max_reg;
    logic [PROT_W-1:0]  prot_mask_reg;

    state_t state_reg;
    state_t state_next;

    req_t req_reg;

    logic [MODE_W-1:0] in_mode;
    logic [ADDR_W-1:0] in_address;
    logic [SIZE_W-1:0] in_size;
    logic [SIZE_W-1:0] in_pages_full;
    status_t           in_add_status;

    logic [ENTRIES:0] tok;
    cell_res_t        cell_res [ENTRIES];
    cell_res_t        any_res;
    logic             finish;
    status_t          fin_status;
    logic [INDEX_W-1:0] fin_index;

    logic               accept;
    logic               out_free;
    logic               load_new;
    logic               load_res;
    logic               hold_res;

    status_t            res_status_reg;
    logic [INDEX_W-1:0] res_index_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [INDEX_W-1:0] out_index_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_flags_reg <= '1;
            size_max_reg    <= '1;
            prot_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FLAGS_ALLOW:    grant_flags_reg <= cfg_data[FLAGS_W-1:0];
                CFG_SIZE_MAX_PAGES: size_max_reg    <= cfg_data[PAGES_W-1:0];
                CFG_PROTECTED_MASK: prot_mask_reg   <= cfg_data[PROT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input unpacking and the add checks, which do not depend on the table.
    assign in_mode       = s_tdata[MODE_W-1:0];
    assign in_address    = s_tdata[MODE_W +: ADDR_W];
    assign in_size       = s_tdata[MODE_W+ADDR_W +: SIZE_W];
    assign in_pages_full = in_size >> PAGE_SHIFT;

    always_comb
    begin
        if ((in_size & SIZE_W'((64'd1 << PAGE_SHIFT) - 64'd1)) != '0)
            in_add_status = ST_SIZE_ALIGN;
        else if ((in_address & ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1)) != '0)
            in_add_status = ST_ADDR_ALIGN;
        else if (in_pages_full > SIZE_W'(size_max_reg))
            in_add_status = ST_TOO_LARGE;
        else
            in_add_status = ST_OK;
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.mode       <= in_mode;
            req_reg.address    <= in_address;
            req_reg.size_bytes <= in_size;
            req_reg.base_page  <= BASE_W'(in_address >> PAGE_SHIFT);
            req_reg.size_pages <= PAGES_W'(in_pages_full);
            req_reg.add_status <= in_add_status;
        end
    end

    // Row of entry cells; tok[i] enters cell i.
    assign tok[0] = accept;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic prot;
        if (i < PROT_W)
        begin : g_prot
            assign prot = prot_mask_reg[i];
        end
        else
        begin : g_noprot
            assign prot = 1'b0;
        end

        dra_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .tok_in      (tok[i]),
            .req         (req_reg),
            .grant_flags (grant_flags_reg),
            .prot        (prot),
            .idx         (INDEX_W'(i)),
            .tok_out     (tok[i+1]),
            .res         (cell_res[i])
        );
    end

    // At most one cell reports at a time, so the reports are simply merged.
    always_comb
    begin
        any_res = '0;
        for (int i = 0; i < ENTRIES; i++)
            any_res = any_res | cell_res[i];
    end

    assign finish = any_res.hit || tok[ENTRIES];

    always_comb
    begin
        fin_index = '0;
        if (any_res.hit)
        begin
            fin_status = any_res.status;
            fin_index  = any_res.index;
        end
        else
        begin
            case (mode_t'(req_reg.mode))
                MODE_ADD:     fin_status = ST_NO_FREE;
                MODE_RELEASE: fin_status = ST_OK;
                default:      fin_status = ST_NOT_FOUND;
            endcase
        end
    end

    // Control state machine.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_SCAN;
            S_SCAN: if (finish) state_next = out_free ? S_IDLE : S_WAIT;
            S_WAIT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        load_new = 1'b0;
        load_res = 1'b0;
        hold_res = 1'b0;
        case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_SCAN:
            begin
                load_new = finish && out_free;
                hold_res = finish && !out_free;
            end
            S_WAIT: load_res = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_new || load_res)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_res)
        begin
            res_status_reg <= fin_status;
            res_index_reg  <= fin_index;
        end
        if (load_new)
        begin
            out_status_reg <= fin_status;
            out_index_reg  <= fin_index;
        end
        else if (load_res)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'({out_index_reg, out_status_reg, (out_status_reg == ST_OK)});

endmodule

`default_nettype wire

@@ rtl/dra_checker.sv @@
`default_nettype none

module dra_checker import dra_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OUT_TW-1:0]    m_tdata
);

    // A result word may not be withdrawn before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped before it was taken");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ST_OK)))
        else $error("ok flag disagrees with status");

    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[7:4] == '0))
        else $error("failed command reports a nonzero entry index");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] <= ST_NOT_FOUND))
        else $error("status code out of range");

    // After an accepted word the input stays closed while its scan starts.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new word accepted while a scan is starting");

endmodule

bind dma_region_allowlist_table_top dra_checker u_dra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ dv/dma_region_allowlist_table_top_tb.sv @@
`timescale 1ns / 100ps

module dma_region_allowlist_table_top_tb;
    import dra_pkg::*;

    // Mode code the block does not define; it must leave the table alone.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int PHASE_ITEMS = 200;
    localparam int PHASES = 8;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size_bytes;
    } command_t;

    typedef struct packed {
        logic               ok;
        status_t            status;
        logic [INDEX_W-1:0] index;
    } verdict_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size_bytes;
    } region_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_TW-1:0]     s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_TW-1:0]    m_tdata;

    dma_region_allowlist_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Shadow copy of the table and its registers.
    logic [FLAGS_W-1:0] shadow_flags [ENTRIES];
    logic [BASE_W-1:0]  shadow_base  [ENTRIES];
    logic [PAGES_W-1:0] shadow_pages [ENTRIES];
    logic [FLAGS_W-1:0] allow_flags = 8'hff;
    logic [PAGES_W-1:0] max_pages = '1;
    logic [PROT_W-1:0]  prot_mask = '0;

    command_t command_q [$];
    verdict_t verdict_q [$];
    region_t  granted_regions [$];

    bit s_taken = 1'b0;
    bit rx_hold = 1'b0;
    int n_accepted = 0;
    int mismatches = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_kind = 0;
    int rx_left = 0;

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_flags[i] = '0;
            shadow_base[i]  = '0;
            shadow_pages[i] = '0;
        end
    end

    function automatic verdict_t allowlist_step(command_t c);
        verdict_t v;
        bit done;
        logic [PAGES_W-1:0] pages;
        v.ok = 1'b0;
        v.status = ST_NOT_FOUND;
        v.index = '0;
        done = 1'b0;
        pages = c.size_bytes[SIZE_W-1:PAGE_SHIFT];
        case (c.mode)
            MODE_ADD:
            begin
                v.status = ST_NO_FREE;
                for (int i = 0; i < ENTRIES && !done; i++)
                begin
                    if (!prot_mask[i] && shadow_flags[i] == '0)
                    begin
                        // Only the first free entry is tried; a failed check ends the add.
                        done = 1'b1;
                        if (c.size_bytes[PAGE_SHIFT-1:0] != '0)
                            v.status = ST_SIZE_ALIGN;
                        else if (c.address[PAGE_SHIFT-1:0] != '0)
                            v.status = ST_ADDR_ALIGN;
                        else if (pages > max_pages)
                            v.status = ST_TOO_LARGE;
                        else
                        begin
                            shadow_base[i]  = c.address[ADDR_W-1:PAGE_SHIFT];
                            shadow_pages[i] = pages;
                            shadow_flags[i] = allow_flags;
                            v.ok = 1'b1;
                            v.status = ST_OK;
                            v.index = i[INDEX_W-1:0];
                        end
                    end
                end
            end
            MODE_REMOVE:
            begin
                for (int i = 0; i < ENTRIES && !done; i++)
                begin
                    if (!prot_mask[i] && shadow_flags[i] != '0
                        && {shadow_base[i], {PAGE_SHIFT{1'b0}}} == c.address
                        && {shadow_pages[i], {PAGE_SHIFT{1'b0}}} == c.size_bytes)
                    begin
                        done = 1'b1;
                        shadow_flags[i] = '0;
                        shadow_base[i]  = '0;
                        shadow_pages[i] = '0;
                        v.ok = 1'b1;
                        v.status = ST_OK;
                        v.index = i[INDEX_W-1:0];
                    end
                end
            end
            MODE_RELEASE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!prot_mask[i])
                    begin
                        shadow_flags[i] = '0;
                        shadow_base[i]  = '0;
                        shadow_pages[i] = '0;
                    end
                end
                v.ok = 1'b1;
                v.status = ST_OK;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic command_t make_command(logic [MODE_W-1:0] mode,
                                              logic [ADDR_W-1:0] address,
                                              logic [SIZE_W-1:0] size_bytes);
        command_t c;
        c.mode = mode;
        c.address = address;
        c.size_bytes = size_bytes;
        return c;
    endfunction

    function automatic command_t random_command();
        command_t c;
        region_t  r;
        logic [63:0] wide;
        int pick;
        pick = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        c.address = wide[ADDR_W-1:0];
        wide = {$urandom, $urandom};
        c.size_bytes = wide[SIZE_W-1:0];
        if (pick < 30)
        begin
            c.mode = MODE_REMOVE;
            // Mostly a region that an earlier add asked for, so that removes find something.
            if (granted_regions.size() != 0 && $urandom_range(0, 9) < 7)
            begin
                r = granted_regions[$urandom_range(0, granted_regions.size() - 1)];
                c.address = r.address;
                c.size_bytes = r.size_bytes;
            end
        end
        else if (pick < 33)
            c.mode = MODE_RELEASE;
        else if (pick < 35)
            c.mode = MODE_SPARE;
        else
        begin
            c.mode = MODE_ADD;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: c.address = ADDR_W'($urandom_range(0, 63)) << PAGE_SHIFT;
                5, 6, 7, 8:    c.address[PAGE_SHIFT-1:0] = '0;
                default: ;
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2: ;
                3, 4, 5, 6, 7: c.size_bytes[PAGE_SHIFT-1:0] = '0;
                default: c.size_bytes = SIZE_W'($urandom_range(0, 40)) << PAGE_SHIFT;
            endcase
            if (c.address[PAGE_SHIFT-1:0] == '0 && c.size_bytes[PAGE_SHIFT-1:0] == '0)
            begin
                r.address = c.address;
                r.size_bytes = c.size_bytes;
                granted_regions.push_back(r);
                if (granted_regions.size() > 24)
                    void'(granted_regions.pop_front());
            end
        end
        return c;
    endfunction

    // Writes all three registers in turn; only called while the block is idle.
    task automatic set_registers(input logic [FLAGS_W-1:0] flags,
                                 input logic [PAGES_W-1:0] limit,
                                 input logic [PROT_W-1:0]  mask);
        logic [CFG_W-1:0] values [3];
        values[0] = {22'($urandom), flags};
        values[1] = limit;
        values[2] = {14'($urandom), mask};
        for (int k = 0; k < 3; k++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= k[CFG_IDX_W-1:0];
            cfg_data <= values[k];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        allow_flags = values[0][FLAGS_W-1:0];
        max_pages = values[1];
        prot_mask = values[2][PROT_W-1:0];
    endtask

    task automatic drain();
        while (command_q.size() != 0 || verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Accepted commands are predicted here and results are checked in order.
    always @(posedge clk)
    begin
        verdict_t seen;
        verdict_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                verdict_q.push_back(allowlist_step(command_q[0]));
                void'(command_q.pop_front());
                s_taken = 1'b1;
                n_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                seen.ok = m_tdata[0];
                seen.status = status_t'(m_tdata[3:1]);
                seen.index = m_tdata[7:4];
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result word with nothing expected: ",
                                  "ok=%0d status=%0d index=%0d"},
                                 $realtime, seen.ok, seen.status, seen.index);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (seen.ok !== want.ok || seen.status !== want.status
                        || seen.index !== want.index)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: expected ok=%0d status=%0d index=%0d, ",
                                      "got ok=%0d status=%0d index=%0d"},
                                     $realtime, want.ok, want.status, want.index,
                                     seen.ok, seen.status, seen.index);
                    end
                end
            end
        end
    end

    // Command driver: bursts of words separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_taken)
        begin
            s_taken = 1'b0;
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (command_q.size() == 0)
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {command_q[0].size_bytes, command_q[0].address, command_q[0].mode};
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Result side stalls on its own pattern and switches between four styles.
    always @(negedge clk)
    begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_kind = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_kind)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Long hold-offs on the result side so that the block backs up into its input.
    initial
    begin
        while (n_accepted < 400)
            @(posedge clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
        while (n_accepted < 1200)
            @(posedge clk);
        rx_hold = 1'b1;
        repeat (150) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [FLAGS_W-1:0] flags;
        logic [PAGES_W-1:0] limit;
        logic [PROT_W-1:0]  mask;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed commands with the reset register values.
        command_q.push_back(make_command(MODE_ADD, '0, '0));
        command_q.push_back(make_command(MODE_ADD, 44'hfff_ffff_f000, 42'h3ff_ffff_f000));
        command_q.push_back(make_command(MODE_ADD, 44'h1000, '1));
        command_q.push_back(make_command(MODE_ADD, '1, 42'h1000));
        command_q.push_back(make_command(MODE_ADD, 44'h1001, 42'h1));
        command_q.push_back(make_command(MODE_REMOVE, 44'hfff_ffff_f000, 42'h3ff_ffff_f000));
        command_q.push_back(make_command(MODE_REMOVE, 44'hfff_ffff_f000, 42'h3ff_ffff_f000));
        command_q.push_back(make_command(MODE_REMOVE, '0, '0));
        command_q.push_back(make_command(MODE_SPARE, '1, '1));
        command_q.push_back(make_command(MODE_ADD, 44'h5000, 42'h2000));
        command_q.push_back(make_command(MODE_ADD, 44'h7000, 42'h1000));
        command_q.push_back(make_command(MODE_RELEASE, '0, '0));
        command_q.push_back(make_command(MODE_REMOVE, 44'h5000, 42'h2000));
        drain();

        // Zero flags keep an added entry free; a zero size limit rejects any nonempty region.
        set_registers(8'h00, '0, 16'h0001);
        command_q.push_back(make_command(MODE_ADD, 44'h3000, 42'h1000));
        command_q.push_back(make_command(MODE_ADD, 44'h3000, '0));
        command_q.push_back(make_command(MODE_ADD, 44'h4000, '0));
        command_q.push_back(make_command(MODE_REMOVE, 44'h4000, '0));
        command_q.push_back(make_command(MODE_RELEASE, '0, '0));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin flags = 8'h5a; limit = '1;  mask = 16'h0000; end
                1: begin flags = 8'hff; limit = '0;  mask = 16'h8001; end
                2: begin flags = 8'h80; limit = PAGES_W'(16);  mask = 16'hffff; end
                3: begin flags = 8'h00; limit = '1;  mask = 16'h0000; end
                4: begin flags = 8'h01; limit = '1;  mask = 16'h00ff; end
                5:
                begin
                    flags = FLAGS_W'($urandom);
                    limit = PAGES_W'($urandom_range(0, 48));
                    mask = PROT_W'($urandom);
                end
                6:
                begin
                    flags = FLAGS_W'($urandom);
                    limit = PAGES_W'($urandom);
                    mask = 16'h0000;
                end
                default: begin flags = 8'hff; limit = '1; mask = 16'haaaa; end
            endcase
            set_registers(flags, limit, mask);
            for (int n = 0; n < PHASE_ITEMS; n++)
                command_q.push_back(random_command());
            drain();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
